/* hdl/dsd_pkg.sv */
// Shared constants and types of the dirty span detector.
package dsd_pkg;

    localparam int PIX_W   = 32;
    localparam int ROW_W   = 11;
    localparam int START_W = 11;
    localparam int END_W   = 12;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // s_tdata: new_pixel, shown_pixel
    localparam int S_DATA_W = 2 * PIX_W;
    // m_tdata: row_index, span_start, span_end, row_changed, zero fill to bytes
    localparam int M_FIELD_W = ROW_W + START_W + END_W + 1;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [START_W-1:0] span_start;
        logic [END_W-1:0]   span_end;
        logic               row_changed;
        logic               full_row;
        logic               frame_done;
    } report_t;

endpackage

/* hdl/dsd_row_track.sv */
// Column/row counters, per-row diff span tracking and span report logic.
module dsd_row_track
    import dsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [PIX_W-1:0] new_pixel,
    input  logic [PIX_W-1:0] shown_pixel,
    input  logic             last_in_row,
    input  logic             last_in_frame,
    output logic             row_end,
    output report_t          report
);

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RCW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
    localparam logic [RCW-1:0]   ROW_LAST = RCW'(MAX_HEIGHT - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [RCW-1:0]   row_reg, row_next;
    logic [COL_W-1:0] first_reg, first_next;
    logic [COL_W:0]   end_reg, end_next;
    logic             any_reg, any_next;
    logic             shadow_reg, shadow_next;

    logic             diff;
    logic [COL_W-1:0] first_eff;
    logic [COL_W:0]   end_eff;
    logic [COL_W:0]   col_inc;
    logic             any_eff;
    logic [COL_W-1:0] start_sel;
    logic [COL_W:0]   end_sel;
    logic [31:0]      row_ext, start_ext, end_ext;

    assign diff    = (new_pixel != shown_pixel);
    assign row_end = last_in_row | last_in_frame;
    assign col_inc = (COL_W+1)'(col_reg) + (COL_W+1)'(1);

    assign first_eff = (diff && !any_reg) ? col_reg : first_reg;
    assign end_eff   = diff ? col_inc : end_reg;
    assign any_eff   = any_reg | diff;

    always_comb begin
        start_sel          = '0;
        end_sel            = '0;
        report.row_changed = 1'b0;
        report.full_row    = 1'b0;
        if (!shadow_reg) begin
            // shown copy not valid yet: whole row up to this column
            end_sel            = col_inc;
            report.row_changed = 1'b1;
            report.full_row    = 1'b1;
        end else if (any_eff) begin
            start_sel          = first_eff;
            end_sel            = end_eff;
            report.row_changed = 1'b1;
        end
        row_ext           = 32'(row_reg);
        start_ext         = 32'(start_sel);
        end_ext           = 32'(end_sel);
        report.row_index  = row_ext[ROW_W-1:0];
        report.span_start = start_ext[START_W-1:0];
        report.span_end   = end_ext[END_W-1:0];
        report.frame_done = last_in_frame;
    end

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        first_next  = first_reg;
        end_next    = end_reg;
        any_next    = any_reg;
        shadow_next = shadow_reg;
        if (accept) begin
            if (!row_end) begin
                first_next = first_eff;
                end_next   = end_eff;
                any_next   = any_eff;
                if (col_reg != COL_LAST) begin
                    col_next = col_reg + COL_W'(1);
                end
            end else begin
                col_next   = '0;
                first_next = '0;
                end_next   = '0;
                any_next   = 1'b0;
                if (last_in_frame) begin
                    row_next    = '0;
                    shadow_next = 1'b1;
                end else if (row_reg != ROW_LAST) begin
                    row_next = row_reg + RCW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            first_reg  <= '0;
            end_reg    <= '0;
            any_reg    <= 1'b0;
            shadow_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            first_reg  <= first_next;
            end_reg    <= end_next;
            any_reg    <= any_next;
            shadow_reg <= shadow_next;
        end
    end

endmodule

/* hdl/dirty_span_detector.sv */
// Dirty span detector top level: stream ports and the report output register.
//
// Takes one pixel pair word per cycle in raster order and, for each word that
// ends a row (tlast or tuser set), emits one span report in the next cycle.
// Words that do not end a row produce nothing. The input keeps accepting a
// word every cycle as long as the report register is empty or being drained
// in the same cycle; a stalled report holds s_tready low until it is taken.
// Until the first frame end has been seen every row is reported whole.
module dirty_span_detector
    import dsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // new_pixel, shown_pixel
    input  logic                s_tlast,   // last_in_row
    input  logic                s_tuser,   // last_in_frame
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // row_index, span_start, span_end, row_changed
    output logic                m_tlast,   // frame_done
    output logic                m_tuser    // full_row
);

    logic    accept;
    logic    row_end;
    report_t report;
    report_t rep_reg;
    logic    valid_reg, valid_next;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    dsd_row_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .new_pixel     (s_tdata[PIX_W-1:0]),
        .shown_pixel   (s_tdata[2*PIX_W-1:PIX_W]),
        .last_in_row   (s_tlast),
        .last_in_frame (s_tuser),
        .row_end       (row_end),
        .report        (report)
    );

    always_comb begin
        valid_next = valid_reg;
        if (accept && row_end) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && row_end) begin
            rep_reg <= report;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_DATA_W'({rep_reg.row_changed, rep_reg.span_end,
                                 rep_reg.span_start, rep_reg.row_index});
    assign m_tlast  = rep_reg.frame_done;
    assign m_tuser  = rep_reg.full_row;

endmodule

/* hdl/dsd_checker.sv */
// Port-level assertions for the dirty span detector, bound to the top level.
module dsd_checker
    import dsd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tlast,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);

    localparam int START_LO = ROW_W;
    localparam int END_LO   = ROW_W + START_W;
    localparam int CHG_BIT  = ROW_W + START_W + END_W;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // a stalled report must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("report changed while stalled");

    // every accepted row-end word yields a report next cycle
    a_report: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tlast || s_tuser) |=> m_tvalid)
        else $error("row end without report");

    // a word that does not end a row adds no report
    a_noreport: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !s_tlast && !s_tuser && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("report without row end");

    // unchanged rows carry an empty span; whole rows start at zero
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (!m_tdata[CHG_BIT] || m_tuser) |->
            m_tdata[END_LO-1:START_LO] == '0 &&
            (m_tdata[CHG_BIT] || (m_tdata[CHG_BIT-1:END_LO] == '0 && !m_tuser)))
        else $error("bad span for unchanged or whole row");

endmodule

bind dirty_span_detector dsd_checker u_dsd_checker (.*);
